>>> hw/rtl/dltq_pkg.sv
// Shared types and codes for the delta-list timer queue.
`default_nettype none
package dltq_pkg;

    localparam int ID_W = 4;

    localparam logic [1:0] OP_ADD     = 2'd0;
    localparam logic [1:0] OP_REMOVE  = 2'd1;
    localparam logic [1:0] OP_ADVANCE = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ADD_IGN = 2'd1;
    localparam logic [1:0] ST_REM_IGN = 2'd2;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SHIFT_IN,
        CELL_SHIFT_OUT,
        CELL_LOAD,
        CELL_DELTA
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t         cmd;
        logic [ID_W-1:0]   id;
    } cell_ctl_t;

endpackage
`default_nettype wire

>>> hw/rtl/dltq_cell.sv
// One list cell: valid flag, timer id and relative delta.
`default_nettype none
module dltq_cell import dltq_pkg::*; #(
    parameter int DW = 32
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire cell_ctl_t       ctl,
    input  wire logic [DW-1:0]   load_delta,
    input  wire logic            prev_valid,
    input  wire logic [ID_W-1:0] prev_id,
    input  wire logic [DW-1:0]   prev_delta,
    input  wire logic            next_valid,
    input  wire logic [ID_W-1:0] next_id,
    input  wire logic [DW-1:0]   next_delta,
    output logic                 valid,
    output logic [ID_W-1:0]      id,
    output logic [DW-1:0]        delta
);

    logic            valid_reg;
    logic [ID_W-1:0] id_reg;
    logic [DW-1:0]   delta_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            case (ctl.cmd)
                CELL_SHIFT_IN:  valid_reg <= prev_valid;
                CELL_SHIFT_OUT: valid_reg <= next_valid;
                CELL_LOAD:      valid_reg <= 1'b1;
                default:        valid_reg <= valid_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (ctl.cmd)
            CELL_SHIFT_IN: begin
                id_reg    <= prev_id;
                delta_reg <= prev_delta;
            end
            CELL_SHIFT_OUT: begin
                id_reg    <= next_id;
                delta_reg <= next_delta;
            end
            CELL_LOAD: begin
                id_reg    <= ctl.id;
                delta_reg <= load_delta;
            end
            CELL_DELTA: begin
                delta_reg <= load_delta;
            end
            default: begin
                id_reg    <= id_reg;
                delta_reg <= delta_reg;
            end
        endcase
    end

    assign valid = valid_reg;
    assign id    = id_reg;
    assign delta = delta_reg;

endmodule
`default_nettype wire

>>> hw/rtl/delta_list_timer_queue.sv
// Delta-list timer queue: cell chain plus command sequencer and result register.
// An add steps past entries to its insert point, a remove completes in S_EXEC, and
// an advance consumes head deltas and expires timers. Ignored, zero-tick and unused
// commands go straight to S_OUT. Further words load as the previous one is taken.
// One command is in flight at a time; the add scan and advance walk the chain head.
// Reset (synchronous, active low) empties the queue; no clearing pass is needed.
`default_nettype none
module delta_list_timer_queue import dltq_pkg::*; #(
    parameter int NUM_TIMERS  = 16,
    parameter int DELAY_WIDTH = 32
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [1:0]       s_opcode,
    input  wire logic [ID_W-1:0]  s_timer_id,
    input  wire logic [31:0]      s_amount,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic                  m_expired,
    output logic [ID_W-1:0]       m_expired_id,
    output logic                  m_last,
    output logic [1:0]            m_status,
    output logic                  m_queue_empty,
    output logic [31:0]           m_head_delay
);

    localparam int N  = NUM_TIMERS;
    localparam int DW = DELAY_WIDTH;
    localparam int PW = $clog2(N);
    localparam int CW = $clog2(N + 1);

    typedef enum logic [2:0] {S_IDLE, S_EXEC, S_ADD, S_ADV, S_OUT} state_t;

    state_t          state_reg, state_next;
    logic [1:0]      op_reg, op_next;
    logic [ID_W-1:0] id_reg, id_next;
    logic [DW-1:0]   rem_reg, rem_next;
    logic [PW-1:0]   pos_reg, pos_next;
    logic [1:0]      status_reg, status_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   exp_cnt_reg, exp_cnt_next;
    logic [ID_W-1:0] exp_buf_reg [N];
    logic [ID_W-1:0] exp_buf_next [N];
    logic            m_valid_reg, m_valid_next;
    logic            m_expired_reg, m_expired_next;
    logic [ID_W-1:0] m_id_reg, m_id_next;
    logic            m_last_reg, m_last_next;
    logic [1:0]      m_status_reg, m_status_next;
    logic            m_empty_reg, m_empty_next;
    logic [DW-1:0]   m_head_reg, m_head_next;

    cell_ctl_t       ctl [N];
    logic [DW-1:0]   ld_delta [N];
    logic            c_valid [N];
    logic [ID_W-1:0] c_id [N];
    logic [DW-1:0]   c_delta [N];
    logic            p_valid [N];
    logic [ID_W-1:0] p_id [N];
    logic [DW-1:0]   p_delta [N];
    logic            n_valid [N];
    logic [ID_W-1:0] n_id [N];
    logic [DW-1:0]   n_delta [N];
    logic [N-1:0]    match;
    logic [N-1:0]    valid_vec;

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            if (g == 0) begin : g_first
                assign p_valid[g] = 1'b0;
                assign p_id[g]    = '0;
                assign p_delta[g] = '0;
            end else begin : g_mid
                assign p_valid[g] = c_valid[g-1];
                assign p_id[g]    = c_id[g-1];
                assign p_delta[g] = c_delta[g-1];
            end
            if (g == N - 1) begin : g_last
                assign n_valid[g] = 1'b0;
                assign n_id[g]    = '0;
                assign n_delta[g] = '0;
            end else begin : g_nxt
                assign n_valid[g] = c_valid[g+1];
                assign n_id[g]    = c_id[g+1];
                assign n_delta[g] = c_delta[g+1];
            end
            assign match[g]     = c_valid[g] && (c_id[g] == id_reg);
            assign valid_vec[g] = c_valid[g];

            dltq_cell #(.DW(DW)) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctl        (ctl[g]),
                .load_delta (ld_delta[g]),
                .prev_valid (p_valid[g]),
                .prev_id    (p_id[g]),
                .prev_delta (p_delta[g]),
                .next_valid (n_valid[g]),
                .next_id    (n_id[g]),
                .next_delta (n_delta[g]),
                .valid      (c_valid[g]),
                .id         (c_id[g]),
                .delta      (c_delta[g])
            );
        end
    endgenerate

    logic          id_ok, pending, add_ok, ins;
    logic          cur_v;
    logic [DW-1:0] cur_d, head_d;
    logic          seen;

    assign id_ok   = 32'(id_reg) < 32'(N);
    assign pending = |match;
    assign add_ok  = id_ok && !pending && (count_reg < CW'(N));
    assign cur_v   = c_valid[pos_reg];
    assign cur_d   = c_delta[pos_reg];
    assign ins     = !cur_v || (rem_reg <= cur_d);
    assign head_d  = c_delta[0];

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        id_next        = id_reg;
        rem_next       = rem_reg;
        pos_next       = pos_reg;
        status_next    = status_reg;
        count_next     = count_reg;
        exp_cnt_next   = exp_cnt_reg;
        exp_buf_next   = exp_buf_reg;
        m_valid_next   = m_valid_reg;
        m_expired_next = m_expired_reg;
        m_id_next      = m_id_reg;
        m_last_next    = m_last_reg;
        m_status_next  = m_status_reg;
        m_empty_next   = m_empty_reg;
        m_head_next    = m_head_reg;
        seen           = 1'b0;
        for (int i = 0; i < N; i++) begin
            ctl[i]      = '{cmd: CELL_HOLD, id: '0};
            ld_delta[i] = '0;
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next    = s_opcode;
                    id_next    = s_timer_id;
                    rem_next   = s_amount[DW-1:0];
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                status_next  = ST_OK;
                exp_cnt_next = '0;
                pos_next     = '0;
                state_next   = S_OUT;
                case (op_reg)
                    OP_ADD: begin
                        if (add_ok) begin
                            state_next = S_ADD;
                        end else begin
                            status_next = ST_ADD_IGN;
                        end
                    end
                    OP_REMOVE: begin
                        if (!id_ok || !pending) begin
                            status_next = ST_REM_IGN;
                        end else begin
                            count_next = count_reg - CW'(1);
                            for (int i = 0; i < N; i++) begin
                                if (match[i] && n_valid[i]) begin
                                    ctl[i]      = '{cmd: CELL_LOAD, id: n_id[i]};
                                    ld_delta[i] = n_delta[i] + c_delta[i];
                                end else if (match[i] || seen) begin
                                    ctl[i] = '{cmd: CELL_SHIFT_OUT, id: '0};
                                end
                                seen = seen | match[i];
                            end
                        end
                    end
                    OP_ADVANCE: begin
                        if (rem_reg != '0) begin
                            state_next = S_ADV;
                        end
                    end
                    default: begin
                        state_next = S_OUT;
                    end
                endcase
            end
            S_ADD: begin
                if (ins) begin
                    for (int i = 0; i < N; i++) begin
                        if (PW'(i) == pos_reg) begin
                            ctl[i]      = '{cmd: CELL_LOAD, id: id_reg};
                            ld_delta[i] = rem_reg;
                        end else if (i > 0 && (PW'(i - 1) == pos_reg) && cur_v) begin
                            ctl[i]      = '{cmd: CELL_LOAD, id: p_id[i]};
                            ld_delta[i] = p_delta[i] - rem_reg;
                        end else if (PW'(i) > pos_reg) begin
                            ctl[i] = '{cmd: CELL_SHIFT_IN, id: '0};
                        end
                    end
                    count_next = count_reg + CW'(1);
                    state_next = S_OUT;
                end else begin
                    rem_next = rem_reg - cur_d;
                    pos_next = pos_reg + PW'(1);
                end
            end
            S_ADV: begin
                if (count_reg == '0) begin
                    state_next = S_OUT;
                end else if (head_d == '0) begin
                    for (int i = 0; i < N; i++) begin
                        ctl[i] = '{cmd: CELL_SHIFT_OUT, id: '0};
                    end
                    exp_buf_next[exp_cnt_reg[PW-1:0]] = c_id[0];
                    exp_cnt_next = exp_cnt_reg + CW'(1);
                    count_next   = count_reg - CW'(1);
                end else if (rem_reg == '0) begin
                    state_next = S_OUT;
                end else if (head_d < rem_reg) begin
                    rem_next    = rem_reg - head_d;
                    ctl[0]      = '{cmd: CELL_DELTA, id: '0};
                    ld_delta[0] = '0;
                end else begin
                    rem_next    = '0;
                    ctl[0]      = '{cmd: CELL_DELTA, id: '0};
                    ld_delta[0] = head_d - rem_reg;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_expired_next = exp_cnt_reg != '0;
                    m_id_next      = (exp_cnt_reg != '0) ? exp_buf_reg[0] : '0;
                    m_last_next    = exp_cnt_reg <= CW'(1);
                    m_status_next  = status_reg;
                    m_empty_next   = count_reg == '0;
                    m_head_next    = (count_reg == '0) ? '0 : head_d;
                    if (exp_cnt_reg != '0) begin
                        exp_cnt_next = exp_cnt_reg - CW'(1);
                        for (int i = 0; i < N - 1; i++) begin
                            exp_buf_next[i] = exp_buf_reg[i+1];
                        end
                    end
                    if (exp_cnt_reg <= CW'(1)) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            exp_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            exp_cnt_reg <= exp_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        id_reg        <= id_next;
        rem_reg       <= rem_next;
        pos_reg       <= pos_next;
        status_reg    <= status_next;
        exp_buf_reg   <= exp_buf_next;
        m_expired_reg <= m_expired_next;
        m_id_reg      <= m_id_next;
        m_last_reg    <= m_last_next;
        m_status_reg  <= m_status_next;
        m_empty_reg   <= m_empty_next;
        m_head_reg    <= m_head_next;
    end

    assign s_ready       = state_reg == S_IDLE;
    assign m_valid       = m_valid_reg;
    assign m_expired     = m_expired_reg;
    assign m_expired_id  = m_id_reg;
    assign m_last        = m_last_reg;
    assign m_status      = m_status_reg;
    assign m_queue_empty = m_empty_reg;
    assign m_head_delay  = 32'(m_head_reg);

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(N)) else $error("pending count exceeds capacity");
    a_count_cells: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_vec) == int'(count_reg)) else $error("count differs from cells");
    a_exp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (int'(exp_cnt_reg) + int'(count_reg)) <= N) else $error("expired buffer overrun");
    a_ids_unique: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EXEC && op_reg == OP_REMOVE) |-> $onehot0(match))
        else $error("duplicate pending id");
`endif

endmodule
`default_nettype wire

>>> verif/tb_delta_list_timer_queue.sv
// Testbench for the delta-list timer queue: directed and random commands checked against a predictor.
`timescale 1ns / 100ps
module tb_delta_list_timer_queue;
    import dltq_pkg::*;

    typedef struct {
        logic        expired;
        logic [3:0]  expired_id;
        logic        last;
        logic [1:0]  status;
        logic        queue_empty;
        logic [31:0] head_delay;
    } timer_word_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_opcode;
    logic [3:0]  s_timer_id;
    logic [31:0] s_amount;
    logic        m_valid;
    logic        m_ready;
    logic        m_expired;
    logic [3:0]  m_expired_id;
    logic        m_last;
    logic [1:0]  m_status;
    logic        m_queue_empty;
    logic [31:0] m_head_delay;

    // predictor state: ordered delta list
    logic [3:0]  list_id[16];
    logic [31:0] list_delta[16];
    int          list_len;
    logic [15:0] armed_map;

    timer_word_t expected_words[$];
    int          error_count;
    int          cycle_count;
    int          send_idle_pct;
    int          recv_stall_pct;

    delta_list_timer_queue DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_opcode(s_opcode),
        .s_timer_id(s_timer_id), .s_amount(s_amount),
        .m_valid(m_valid), .m_ready(m_ready), .m_expired(m_expired),
        .m_expired_id(m_expired_id), .m_last(m_last), .m_status(m_status),
        .m_queue_empty(m_queue_empty), .m_head_delay(m_head_delay)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %0h expected %0h at cycle %0d", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    task automatic drop_entry(input int pos);
        armed_map[list_id[pos]] = 1'b0;
        for (int i = pos; i + 1 < list_len; i++) begin
            list_id[i] = list_id[i + 1];
            list_delta[i] = list_delta[i + 1];
        end
        list_len--;
    endtask

    task automatic predict_command(input logic [1:0] op, input logic [3:0] id,
                                   input logic [31:0] amt);
        timer_word_t batch[$];
        timer_word_t w;
        logic [1:0]  st;
        logic [31:0] left;
        int          pos;
        st = ST_OK;
        w = '{default: '0};
        if (op == OP_ADD) begin
            if (armed_map[id] || list_len >= 16) begin
                st = ST_ADD_IGN;
            end else begin
                left = amt;
                pos = 0;
                while (pos < list_len && left > list_delta[pos]) begin
                    left -= list_delta[pos];
                    pos++;
                end
                if (pos < list_len) list_delta[pos] -= left;
                for (int i = list_len; i > pos; i--) begin
                    list_id[i] = list_id[i - 1];
                    list_delta[i] = list_delta[i - 1];
                end
                list_id[pos] = id;
                list_delta[pos] = left;
                list_len++;
                armed_map[id] = 1'b1;
            end
            batch.push_back(w);
        end else if (op == OP_REMOVE) begin
            if (!armed_map[id]) begin
                st = ST_REM_IGN;
            end else begin
                pos = 0;
                while (list_id[pos] != id) pos++;
                if (pos + 1 < list_len) list_delta[pos + 1] += list_delta[pos];
                drop_entry(pos);
            end
            batch.push_back(w);
        end else if (op == OP_ADVANCE) begin
            left = amt;
            while (left > 0 && list_len > 0) begin
                if (list_delta[0] < left) begin
                    left -= list_delta[0];
                    list_delta[0] = 0;
                end else begin
                    list_delta[0] -= left;
                    left = 0;
                    if (list_delta[0] > 0) break;
                end
                while (list_len > 0 && list_delta[0] == 0) begin
                    w.expired = 1'b1;
                    w.expired_id = list_id[0];
                    drop_entry(0);
                    batch.push_back(w);
                end
            end
            if (batch.size() == 0) batch.push_back('{default: '0});
        end else begin
            batch.push_back(w);
        end
        foreach (batch[k]) begin
            batch[k].last = (k == batch.size() - 1);
            batch[k].status = st;
            batch[k].queue_empty = (list_len == 0);
            batch[k].head_delay = (list_len == 0) ? 32'd0 : list_delta[0];
            expected_words.push_back(batch[k]);
        end
    endtask

    task automatic send_command(input logic [1:0] op, input logic [3:0] id,
                                input logic [31:0] amt);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= op;
        s_timer_id <= id;
        s_amount <= amt;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_command(op, id, amt);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_words.size() != 0) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        timer_word_t want;
        cycle_count++;
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected word", 32'd0, 32'd0);
            end else begin
                want = expected_words.pop_front();
                if (m_expired !== want.expired)
                    report_mismatch("expired", 32'(m_expired), 32'(want.expired));
                if (m_expired_id !== want.expired_id)
                    report_mismatch("expired_id", 32'(m_expired_id), 32'(want.expired_id));
                if (m_last !== want.last)
                    report_mismatch("last", 32'(m_last), 32'(want.last));
                if (m_status !== want.status)
                    report_mismatch("status", 32'(m_status), 32'(want.status));
                if (m_queue_empty !== want.queue_empty)
                    report_mismatch("queue_empty", 32'(m_queue_empty), 32'(want.queue_empty));
                if (m_head_delay !== want.head_delay)
                    report_mismatch("head_delay", m_head_delay, want.head_delay);
            end
        end
        if (cycle_count > 400000) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic test_directed();
        send_command(OP_ADVANCE, 4'd0, 32'd5);
        send_command(OP_REMOVE, 4'd3, 32'd0);
        send_command(OP_ADD, 4'd0, 32'd0);
        send_command(OP_ADD, 4'd15, 32'hFFFF_FFFF);
        send_command(OP_ADD, 4'd5, 32'd10);
        send_command(OP_ADD, 4'd6, 32'd10);
        send_command(OP_ADD, 4'd7, 32'd4);
        send_command(OP_ADD, 4'd5, 32'd1);
        send_command(OP_ADVANCE, 4'd0, 32'd0);
        send_command(2'd3, 4'd9, 32'hA5A5_5A5A);
        send_command(OP_REMOVE, 4'd7, 32'd0);
        send_command(OP_ADVANCE, 4'd0, 32'd1);
        send_command(OP_ADVANCE, 4'd0, 32'd9);
        send_command(OP_REMOVE, 4'd15, 32'd0);
        send_command(OP_REMOVE, 4'd15, 32'd0);
        for (int i = 0; i < 16; i++) send_command(OP_ADD, i[3:0], 32'd3);
        send_command(OP_ADVANCE, 4'd0, 32'hFFFF_FFFF);
        drain_results();
    endtask

    task automatic test_random(input int count, input int idle_pct, input int stall_pct);
        int          r;
        logic [31:0] amt;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            amt = ($urandom_range(9) == 0) ? $urandom : $urandom_range(40);
            if (r < 50) send_command(OP_ADD, 4'($urandom_range(15)), amt);
            else if (r < 70) send_command(OP_REMOVE, 4'($urandom_range(15)), 32'd0);
            else if (r < 97) send_command(OP_ADVANCE, 4'($urandom_range(15)), amt);
            else send_command(2'd3, 4'($urandom_range(15)), $urandom);
        end
        drain_results();
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_opcode = OP_ADD;
        s_timer_id = '0;
        s_amount = '0;
        m_ready = 1'b0;
        list_len = 0;
        armed_map = '0;
        error_count = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(50, 0, 0);
        test_random(50, 69, 0);
        test_random(50, 0, 69);
        test_random(50, 7, 7);
        repeat (100) @(posedge aclk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
